// ===== rtl/ipv4dq_pkg.sv =====
// Package with the character codes and helpers of the dotted-quad address parser.
package ipv4dq_pkg;

  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [8:0] AccSat    = 9'd256;
  localparam logic [8:0] OctetMax  = 9'd255;
  localparam logic [1:0] LastOctet = 2'd3;

  // The stored octets sit in the top bytes of the address, the rest are zero.
  function automatic logic [31:0] partial_address(input logic [23:0] stored,
                                                  input logic [1:0]  idx);
    logic [31:0] addr;
    begin
      unique case (idx)
        2'd0: addr = 32'd0;
        2'd1: addr = {stored[7:0], 24'd0};
        2'd2: addr = {stored[15:0], 16'd0};
        2'd3: addr = {stored, 8'd0};
        default: addr = 32'd0;
      endcase
      return addr;
    end
  endfunction

endpackage

// ===== rtl/ipv4_dotted_quad_parser.sv =====
// Streaming parser of IPv4 addresses written in dotted decimal text.
//
// The slave channel carries one character a beat in tdata; tuser marks the
// first character of a new address string. Digits build the current octet,
// a dot closes each of the first three octets and any non-digit closes the
// fourth. When the address ends, or at the first error, one result beat
// leaves on the master channel: tdata holds the address with the first
// octet in the top byte, tuser is high when all four octets parsed.
// On error the octets not yet stored read as zero. Characters after a result
// and before the next first character are dropped without a result.
// The result beat is registered: it appears in the cycle after the
// character that ends the address. One character is taken every cycle; the
// only limit is the single result register, which accepts a new beat when it
// is empty or being drained in the same cycle. When the receiver stalls with
// a result waiting, tready on the slave side falls until that beat is taken.
// Synchronous reset stops parsing, clears the octet state and empties the
// result register.
module ipv4_dotted_quad_parser
  import ipv4dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] address
  output logic        m_axis_tuser    // [0] valid_addr
);

  logic        active;
  logic [1:0]  octet_index;
  logic [8:0]  octet_accum;
  logic [23:0] stored_octets;

  logic        active_next;
  logic [1:0]  octet_index_next;
  logic [8:0]  octet_accum_next;
  logic [23:0] stored_octets_next;

  logic        emit;
  logic        emit_ok;
  logic [31:0] emit_addr;

  logic        in_beat;
  logic        run;
  logic [1:0]  idx_cur;
  logic [8:0]  acc_cur;
  logic [23:0] st_cur;
  logic        is_digit;
  logic [12:0] acc_sum;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    run      = s_axis_tuser || active;
    idx_cur  = s_axis_tuser ? 2'd0 : octet_index;
    acc_cur  = s_axis_tuser ? 9'd0 : octet_accum;
    st_cur   = s_axis_tuser ? 24'd0 : stored_octets;
    is_digit = (s_axis_tdata >= CharZero) && (s_axis_tdata <= CharNine);
    acc_sum  = {1'b0, acc_cur, 3'b000} + {3'b000, acc_cur, 1'b0}
             + {5'd0, s_axis_tdata - CharZero};

    active_next        = run;
    octet_index_next   = idx_cur;
    octet_accum_next   = acc_cur;
    stored_octets_next = st_cur;
    emit               = 1'b0;
    emit_ok            = 1'b0;
    emit_addr          = partial_address(st_cur, idx_cur);

    if (run) begin
      if (is_digit) begin
        octet_accum_next = (acc_sum > {4'd0, AccSat}) ? AccSat : acc_sum[8:0];
      end else if (idx_cur != LastOctet) begin
        if ((s_axis_tdata != CharDot) || (acc_cur > OctetMax)) begin
          emit        = 1'b1;
          active_next = 1'b0;
        end else begin
          stored_octets_next = {st_cur[15:0], acc_cur[7:0]};
          octet_index_next   = idx_cur + 2'd1;
          octet_accum_next   = 9'd0;
        end
      end else begin
        emit        = 1'b1;
        active_next = 1'b0;
        if (acc_cur <= OctetMax) begin
          emit_ok   = 1'b1;
          emit_addr = {st_cur, acc_cur[7:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      octet_index   <= 2'd0;
      octet_accum   <= 9'd0;
      stored_octets <= 24'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_beat && emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_beat) begin
        active        <= active_next;
        octet_index   <= octet_index_next;
        octet_accum   <= octet_accum_next;
        stored_octets <= stored_octets_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && emit) begin
      m_axis_tdata <= emit_addr;
      m_axis_tuser <= emit_ok;
    end
  end

endmodule
